### rtl/core/mwc_lag256_random_generator_core_defines.svh
// assertion macros for the lag-256 multiply-with-carry generator core
// no dependencies; taken in by `include where assertions are written
`ifndef MWC_LAG256_RANDOM_GENERATOR_CORE_DEFINES_SVH
`define MWC_LAG256_RANDOM_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, held off while reset is asserted
`define MWC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define MWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MWC_ASSERT_CLK(lbl, prop, msg)
`define MWC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/mwc_pkg.sv
// shared constants and types for the lag-256 multiply-with-carry generator
// no dependencies
package mwc_pkg;

  localparam int unsigned LAG_DEPTH_DEF = 256;

  localparam logic [31:0] MWC_MULT   = 32'd1540315826;
  localparam logic [63:0] SEED_OR    = 64'h0000_0000_4000_0005;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam logic [31:0] CARRY_INIT = 32'd123;

  // redraw bound: at most 65536 draws per table entry
  localparam int unsigned TRY_W = 16;

  // item kinds carried on tuser
  localparam logic KIND_NEXT   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_NMUL = 7'b0000010,
    S_NADD = 7'b0000100,
    S_NOUT = 7'b0001000,
    S_SMUL = 7'b0010000,
    S_SSQ  = 7'b0100000,
    S_SADD = 7'b1000000
  } state_t;

endpackage

### rtl/core/mwc_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module mwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/mwc_lag256_random_generator_core.sv
// top level of the lag-256 multiply-with-carry random word generator
// depends on mwc_pkg, mwc_ram and mwc_lag256_random_generator_core_defines.svh
//
// Lag-256 multiply-with-carry generator in base 2^32-1 with multiplier
// 1540315826. An input transfer with tuser = 0 asks for the next word: the
// table position steps by one (wrapping), t = mult * table[pos] + carry is
// formed, the upper half of t becomes the new carry and the lower half plus
// carry (with the end-around increment of word and carry on overflow) is
// written back and sent as one output transfer. An input transfer with
// tuser = 1 reseeds: the 64-bit tdata seed is stepped by
// seed += (seed*seed | 0x40000005) and the upper half of each step fills the
// table entries 0..255 in turn, redrawing an all-ones half (at most 65536
// draws per entry); carry is then 123 and position 255, and no output
// transfer follows. A reseed must come before the first next-word request.
// A next-word request passes from its input transfer to the output register
// in steps: table read issued with the transfer, 32x32 multiply, add of
// carry, then end-around fold, write-back and load, where the fold waits
// while the output register still holds an untaken word. tready stays low
// until the word is loaded, so a request is taken only once the last is
// through; the output register lets a new request be accepted while the
// last word still waits. Each reseed draw forms two 32x32 partial products
// of the seed square, assembles the square, then does the seed add; the lag
// table lives in one synchronous ram.
`include "mwc_lag256_random_generator_core_defines.svh"

module mwc_lag256_random_generator_core #(
  parameter int unsigned LAG_DEPTH = mwc_pkg::LAG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] seed
  input  logic        in_tuser,   // [0] kind (0 next word, 1 reseed)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] random_word
);

  localparam int unsigned PTR_W = $clog2(LAG_DEPTH);
  localparam int unsigned TRY_W = mwc_pkg::TRY_W;

  mwc_pkg::state_t state_r, state_nxt;

  logic [PTR_W-1:0] pos_r, pos_nxt;        // table position
  logic [31:0]      carry_r, carry_nxt;    // multiply-with-carry carry
  logic [PTR_W-1:0] idx_r, idx_nxt;        // reseed fill index
  logic [TRY_W-1:0] tries_r, tries_nxt;    // draws spent on current entry
  logic [63:0]      seed_r, seed_nxt;      // running seed during reseed
  logic [63:0]      prod_r, prod_nxt;      // mult * table word, or seed lo*lo
  logic [31:0]      cross_r, cross_nxt;    // low half of seed lo*hi
  logic [63:0]      acc_r, acc_nxt;        // t, or seed square
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [31:0]      out_tdata_r, out_tdata_nxt;

  logic             in_xfer;
  logic             out_free;
  logic [32:0]      fold_sum;
  logic             fold_ovf;
  logic [31:0]      fold_word;
  logic [31:0]      fold_carry;
  logic [63:0]      seed_step;
  logic [31:0]      draw;
  logic             redraw;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [31:0]      ram_rdata;

  assign in_tready  = (state_r == mwc_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // end-around fold of t for base 2^32-1
  assign fold_sum   = {1'b0, acc_r[31:0]} + {1'b0, acc_r[63:32]};
  assign fold_ovf   = fold_sum[32];
  assign fold_word  = fold_sum[31:0] + {31'd0, fold_ovf};
  assign fold_carry = acc_r[63:32] + {31'd0, fold_ovf};

  // seed step, square already assembled in acc_r
  assign seed_step = seed_r + (acc_r | mwc_pkg::SEED_OR);
  assign draw      = seed_step[63:32];
  assign redraw    = (draw == mwc_pkg::ALL_ONES32) && (tries_r != {TRY_W{1'b1}});

  // table read is issued with the input transfer, data lands in S_NMUL
  assign ram_re    = in_xfer && (in_tuser == mwc_pkg::KIND_NEXT);
  assign ram_we    = ((state_r == mwc_pkg::S_NOUT) && out_free) ||
                     ((state_r == mwc_pkg::S_SADD) && !redraw);
  assign ram_waddr = (state_r == mwc_pkg::S_NOUT) ? pos_r : idx_r;
  assign ram_wdata = (state_r == mwc_pkg::S_NOUT) ? fold_word : draw;

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    carry_nxt      = carry_r;
    idx_nxt        = idx_r;
    tries_nxt      = tries_r;
    seed_nxt       = seed_r;
    prod_nxt       = prod_r;
    cross_nxt      = cross_r;
    acc_nxt        = acc_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      mwc_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == mwc_pkg::KIND_RESEED) begin
            seed_nxt  = in_tdata;
            idx_nxt   = '0;
            tries_nxt = '0;
            state_nxt = mwc_pkg::S_SMUL;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = mwc_pkg::S_NMUL;
          end
        end
      end
      mwc_pkg::S_NMUL: begin
        prod_nxt  = 64'(mwc_pkg::MWC_MULT) * 64'(ram_rdata);
        state_nxt = mwc_pkg::S_NADD;
      end
      mwc_pkg::S_NADD: begin
        acc_nxt   = prod_r + {32'd0, carry_r};
        state_nxt = mwc_pkg::S_NOUT;
      end
      mwc_pkg::S_NOUT: begin
        // hold the finished word until the output register is free
        if (out_free) begin
          carry_nxt      = fold_carry;
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = fold_word;
          state_nxt      = mwc_pkg::S_IDLE;
        end
      end
      mwc_pkg::S_SMUL: begin
        // seed^2 mod 2^64 = lo*lo + 2*(lo*hi) << 32
        prod_nxt  = 64'(seed_r[31:0]) * 64'(seed_r[31:0]);
        cross_nxt = seed_r[31:0] * seed_r[63:32];
        state_nxt = mwc_pkg::S_SSQ;
      end
      mwc_pkg::S_SSQ: begin
        acc_nxt   = {prod_r[63:32] + {cross_r[30:0], 1'b0}, prod_r[31:0]};
        state_nxt = mwc_pkg::S_SADD;
      end
      mwc_pkg::S_SADD: begin
        seed_nxt  = seed_step;
        state_nxt = mwc_pkg::S_SMUL;
        if (redraw) begin
          tries_nxt = tries_r + 1'b1;
        end else begin
          tries_nxt = '0;
          idx_nxt   = idx_r + 1'b1;
          if (idx_r == PTR_W'(LAG_DEPTH - 1)) begin
            carry_nxt = mwc_pkg::CARRY_INIT;
            pos_nxt   = '1;
            state_nxt = mwc_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mwc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mwc_pkg::S_IDLE;
      pos_r        <= '1;
      carry_r      <= mwc_pkg::CARRY_INIT;
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
      tries_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      carry_r      <= carry_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      idx_r        <= idx_nxt;
      tries_r      <= tries_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r      <= seed_nxt;
    prod_r      <= prod_nxt;
    cross_r     <= cross_nxt;
    acc_r       <= acc_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  mwc_ram #(
    .WIDTH (32),
    .DEPTH (LAG_DEPTH)
  ) u_lag_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (pos_r + 1'b1),
    .rd_data (ram_rdata)
  );

  // a new output word only ever comes out of the fold stage
  `MWC_ASSERT_CLK(a_out_from_fold,
    $rose(out_tvalid_r) |-> $past(state_r == mwc_pkg::S_NOUT),
    "output valid rose without a folded word")

  // table writes happen only at fold or reseed-fill time
  `MWC_ASSERT_ALWAYS(a_ram_we_state,
    ram_we |-> (state_r == mwc_pkg::S_NOUT || state_r == mwc_pkg::S_SADD),
    "table written outside fold or fill")

  // a next-word request advances the position by exactly one
  `MWC_ASSERT_CLK(a_pos_step,
    (in_xfer && in_tuser == mwc_pkg::KIND_NEXT) |=> (pos_r == $past(pos_r) + 1'b1),
    "position did not step on next-word request")

  // end of a reseed leaves carry and position at their start values
  `MWC_ASSERT_CLK(a_reseed_done,
    (state_r == mwc_pkg::S_SADD && !redraw && idx_r == PTR_W'(LAG_DEPTH - 1)) |=>
      (pos_r == {PTR_W{1'b1}} && carry_r == mwc_pkg::CARRY_INIT &&
       state_r == mwc_pkg::S_IDLE),
    "reseed did not restore carry and position")

endmodule

### sim/mwc_lag256_random_generator_core_test.sv
// self-checking testbench for mwc_lag256_random_generator_core
// needs mwc_pkg and the core rtl; predicts every word in step with the input transfers
module mwc_lag256_random_generator_core_test;

  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  // long enough for a full reseed walk to finish after the last word
  localparam int unsigned SETTLE_CYCLES  = 1000;
  localparam int unsigned REDRAW_BOUND   = 1 << mwc_pkg::TRY_W;
  localparam logic [7:0]  POS_START      = 8'hFF;
  // first seed step lands on an all-ones upper half, so entry 0 is redrawn
  localparam logic [63:0] REDRAW_SEED    = 64'hFFFF_FFFF_0000_0000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  // predicted generator state
  logic [31:0] lag_words [mwc_pkg::LAG_DEPTH_DEF];
  logic [31:0] carry_now;
  logic [7:0]  pos_now;

  // words predicted but not yet seen on the output
  logic [31:0] pending_words [$];
  logic [31:0] want_word;
  int unsigned fail_count = 0;

  // sender burst shaping and receiver stall shaping
  int unsigned burst_left    = 0;
  bit          sender_steady = 1'b0;
  int unsigned stall_hold    = 0;
  int unsigned rx_mode       = 0;
  int unsigned rx_mode_left  = 0;
  int unsigned rx_phase      = 0;

  always #HALF_PERIOD clk = ~clk;

  mwc_lag256_random_generator_core #(
    .LAG_DEPTH(mwc_pkg::LAG_DEPTH_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // refill the predicted table from a seed, redrawing all-ones halves
  function automatic void reseed_table(input logic [63:0] seed);
    logic [63:0] walk;
    logic [31:0] upper;
    int unsigned tries;
    bit          redraw;
    walk = seed;
    for (int i = 0; i < mwc_pkg::LAG_DEPTH_DEF; i++) begin
      tries  = 0;
      redraw = 1'b1;
      while (redraw) begin
        walk   = walk + ((walk * walk) | mwc_pkg::SEED_OR);
        upper  = walk[63:32];
        tries  = tries + 1;
        redraw = (upper == mwc_pkg::ALL_ONES32) && (tries < REDRAW_BOUND);
      end
      lag_words[i] = upper;
    end
    carry_now = mwc_pkg::CARRY_INIT;
    pos_now   = POS_START;
  endfunction

  // one multiply-with-carry step in base 2^32-1
  function automatic logic [31:0] next_word_of_table();
    logic [63:0] prod;
    logic [31:0] carry_new;
    logic [31:0] word;
    logic [7:0]  p;
    p         = pos_now + 8'd1;
    prod      = {32'd0, mwc_pkg::MWC_MULT} * {32'd0, lag_words[p]} + {32'd0, carry_now};
    carry_new = prod[63:32];
    word      = prod[31:0] + carry_new;
    // end-around fix when the add wrapped
    if (word < carry_new) begin
      word      = word + 32'd1;
      carry_new = carry_new + 32'd1;
    end
    lag_words[p] = word;
    carry_now    = carry_new;
    pos_now      = p;
    return word;
  endfunction

  // offer one item; returns at the edge where the transfer happened
  task automatic send_item(input logic kind, input logic [63:0] seed);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!sender_steady) begin
        gap = $urandom_range(1, 7);
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    if (gap != 0) begin
      // junk on the bus while not valid
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      in_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    // next-word items carry random, unused data
    in_tdata  <= (kind == mwc_pkg::KIND_RESEED) ? seed : {$urandom, $urandom};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == mwc_pkg::KIND_RESEED) begin
      reseed_table(seed);
    end else begin
      pending_words.push_back(next_word_of_table());
    end
  endtask

  task automatic send_words(input int unsigned count);
    repeat (count) send_item(mwc_pkg::KIND_NEXT, 64'd0);
  endtask

  // drop valid and wait for every predicted word to come out
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // seed extremes, the redraw case and back-to-back reseeds
  task automatic test_directed();
    send_item(mwc_pkg::KIND_RESEED, 64'd0);
    send_words(3);
    send_item(mwc_pkg::KIND_RESEED, '1);
    send_words(3);
    send_item(mwc_pkg::KIND_RESEED, REDRAW_SEED);
    send_words(3);
    // second reseed overrides the first
    send_item(mwc_pkg::KIND_RESEED, {$urandom, $urandom});
    send_item(mwc_pkg::KIND_RESEED, 64'h8000_0000_0000_0001);
    send_words(3);
    // reseed in the middle of a run resets carry and position
    send_item(mwc_pkg::KIND_RESEED, 64'd1);
    send_words(2);
  endtask

  // walk past position 255 so written-back words get read again
  task automatic test_position_wrap();
    send_item(mwc_pkg::KIND_RESEED, {$urandom, $urandom});
    send_words(300);
  endtask

  // receiver holds off long enough for the core to stall its input
  task automatic test_output_stall();
    send_item(mwc_pkg::KIND_RESEED, {$urandom, $urandom});
    send_words(1);
    stall_hold = 300;
    send_words(15);
  endtask

  // sender pauses until the output has fully drained, then resumes
  task automatic test_drain_pause();
    send_item(mwc_pkg::KIND_RESEED, {$urandom, $urandom});
    send_words(10);
    wait_drained();
    send_words(10);
  endtask

  // runs of words after a reseed, with some long runs and doubled reseeds
  task automatic test_random_streams(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    logic [63:0] seed;
    sent = 0;
    while (sent < target) begin
      pick          = $urandom_range(0, 15);
      sender_steady = ($urandom_range(0, 3) == 0);
      seed          = {$urandom, $urandom};
      if (pick == 0) begin
        seed = REDRAW_SEED;
      end else if (pick == 1) begin
        seed[63:32] = mwc_pkg::ALL_ONES32;
      end
      send_item(mwc_pkg::KIND_RESEED, seed);
      sent = sent + 1;
      if (pick == 2) begin
        send_item(mwc_pkg::KIND_RESEED, {$urandom, $urandom});
        sent = sent + 1;
      end
      run_len = (pick == 3) ? $urandom_range(260, 400) : $urandom_range(1, 60);
      send_words(run_len);
      sent = sent + run_len;
    end
    sender_steady = 1'b0;
  endtask

  // receiver: long hold when asked, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_tready <= 1'b0;
      stall_hold = stall_hold - 1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 120);
      end
      rx_mode_left = rx_mode_left - 1;
      rx_phase     = rx_phase + 1;
      case (rx_mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_tready <= (rx_phase % 3 == 0);
        end
      endcase
    end
  end

  // compare each output transfer with the oldest predicted word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("random_word: unexpected output transfer, actual %h", out_tdata);
        fail_count = fail_count + 1;
      end else begin
        want_word = pending_words.pop_front();
        if (out_tdata !== want_word) begin
          $error("random_word mismatch: expected %h, actual %h", want_word, out_tdata);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = mwc_pkg::KIND_NEXT;
    in_tdata   = 64'd0;
    out_tready = 1'b0;
    carry_now  = mwc_pkg::CARRY_INIT;
    pos_now    = POS_START;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_position_wrap();
    test_output_stall();
    test_drain_pause();
    test_random_streams(1300);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("random_word: %0d predicted words never arrived", pending_words.size());
      fail_count = fail_count + 1;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mwc_pkg.sv
rtl/core/mwc_ram.sv
rtl/core/mwc_lag256_random_generator_core.sv
sim/mwc_lag256_random_generator_core_test.sv
